// File: rtl/shamir_secret_recombine_gf256_unit_defines.svh
// Assertion macros shared by ssr_ctrl.sv and ssr_dp.sv.
`ifndef SHAMIR_SECRET_RECOMBINE_GF256_UNIT_DEFINES_SVH
`define SHAMIR_SECRET_RECOMBINE_GF256_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SSR_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define SSR_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SSR_ASSERT_IMP(lbl, pre, post)
`define SSR_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// File: rtl/ssr_pkg.sv
`timescale 1ns / 1ps
package ssr_pkg;

  localparam int SHARE_SLOTS_DEF = 8;
  localparam int IDX_W = 3;
  localparam logic [8:0] POLY_RESET = 9'd285;

  localparam logic [1:0] CFG_COORDS = 2'd0;
  localparam logic [1:0] CFG_THR    = 2'd1;
  localparam logic [1:0] CFG_INTEG  = 2'd2;
  localparam logic [1:0] CFG_POLY   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_TGT_INIT = 4'd2;
  localparam logic [3:0] OP_DEN_INIT = 4'd3;
  localparam logic [3:0] OP_DEN_STEP = 4'd4;
  localparam logic [3:0] OP_INV_INIT = 4'd5;
  localparam logic [3:0] OP_INV_SQ   = 4'd6;
  localparam logic [3:0] OP_INV_MUL  = 4'd7;
  localparam logic [3:0] OP_NUM_STEP = 4'd8;
  localparam logic [3:0] OP_Y_ACC    = 4'd9;
  localparam logic [3:0] OP_TGT_END  = 4'd10;
  localparam logic [3:0] OP_OUT      = 4'd11;

  typedef struct packed {
    logic [3:0]       op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] tgt;
  } cmd_t;

  typedef struct packed {
    logic             bad;
    logic [3:0]       nb;
    logic [IDX_W-1:0] nc;
    logic             out_free;
  } sts_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] r;
    logic [7:0] aa;
    r  = '0;
    aa = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) r = r ^ aa;
      aa = aa[7] ? ({aa[6:0], 1'b0} ^ red) : {aa[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/ssr_ctrl.sv
`timescale 1ns / 1ps
`include "shamir_secret_recombine_gf256_unit_defines.svh"
module ssr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  output logic          in_ready,
  input  ssr_pkg::sts_t sts,
  output ssr_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TINIT    = 4'd1;
  localparam logic [3:0] S_DEN_INIT = 4'd2;
  localparam logic [3:0] S_DEN      = 4'd3;
  localparam logic [3:0] S_INV_INIT = 4'd4;
  localparam logic [3:0] S_INV_SQ   = 4'd5;
  localparam logic [3:0] S_INV_MUL  = 4'd6;
  localparam logic [3:0] S_NUM      = 4'd7;
  localparam logic [3:0] S_YACC     = 4'd8;
  localparam logic [3:0] S_TEND     = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [ssr_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, tgt_r, tgt_nxt, it_r, it_nxt;
  logic j_last, i_last;

  assign j_last   = ({1'b0, j_r} == sts.nb - 4'd1);
  assign i_last   = ({1'b0, i_r} == sts.nb - 4'd1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    tgt_nxt   = tgt_r;
    it_nxt    = it_r;
    cmd.op    = ssr_pkg::OP_NONE;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.tgt   = tgt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = ssr_pkg::OP_LOAD;
          tgt_nxt   = '0;
          state_nxt = sts.bad ? S_OUT : S_TINIT;
        end
      end
      S_TINIT: begin
        cmd.op    = ssr_pkg::OP_TGT_INIT;
        i_nxt     = '0;
        state_nxt = S_DEN_INIT;
      end
      S_DEN_INIT: begin
        cmd.op    = ssr_pkg::OP_DEN_INIT;
        j_nxt     = '0;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.op = ssr_pkg::OP_DEN_STEP;
        if (j_last) state_nxt = S_INV_INIT;
        else j_nxt = j_r + 1'b1;
      end
      S_INV_INIT: begin
        cmd.op    = ssr_pkg::OP_INV_INIT;
        it_nxt    = '0;
        state_nxt = S_INV_SQ;
      end
      S_INV_SQ: begin
        cmd.op    = ssr_pkg::OP_INV_SQ;
        state_nxt = S_INV_MUL;
      end
      S_INV_MUL: begin
        cmd.op = ssr_pkg::OP_INV_MUL;
        if (it_r == 3'd6) begin
          j_nxt     = '0;
          state_nxt = S_NUM;
        end else begin
          it_nxt    = it_r + 1'b1;
          state_nxt = S_INV_SQ;
        end
      end
      S_NUM: begin
        cmd.op = ssr_pkg::OP_NUM_STEP;
        if (j_last) state_nxt = S_YACC;
        else j_nxt = j_r + 1'b1;
      end
      S_YACC: begin
        cmd.op = ssr_pkg::OP_Y_ACC;
        if (i_last) state_nxt = S_TEND;
        else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_DEN_INIT;
        end
      end
      S_TEND: begin
        cmd.op = ssr_pkg::OP_TGT_END;
        if (tgt_r == sts.nc) state_nxt = S_OUT;
        else begin
          tgt_nxt   = tgt_r + 1'b1;
          state_nxt = S_TINIT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = ssr_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      tgt_r   <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      tgt_r   <= tgt_nxt;
      it_r    <= it_nxt;
    end
  end

  `SSR_ASSERT_IMP(a_j_in_range, state_r == S_DEN || state_r == S_NUM, {1'b0, j_r} < sts.nb)
  `SSR_ASSERT_NXT(a_accept_busy, in_fire, state_r != S_IDLE)

endmodule

// File: rtl/ssr_dp.sv
`timescale 1ns / 1ps
`include "shamir_secret_recombine_gf256_unit_defines.svh"
module ssr_dp #(
  parameter int SHARE_SLOTS = ssr_pkg::SHARE_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_wdata,
  input  logic [63:0]   in_data,
  input  logic          in_last,
  output logic [15:0]   out_data,
  output logic          out_last,
  output logic          out_valid,
  input  logic          out_ready,
  input  ssr_pkg::cmd_t cmd,
  output ssr_pkg::sts_t sts
);

  logic [63:0] coords_r;
  logic [3:0]  thr_r, integ_r;
  logic [8:0]  poly_r;
  logic [7:0]  y_r [SHARE_SLOTS];
  logic        final_r;
  logic [7:0]  acc_r, sq_r, pred_r, secret_r;
  logic        mism_r, flag_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r;

  logic [7:0]  x [8];
  logic [ssr_pkg::IDX_W-1:0] bidx [8];
  logic [ssr_pkg::IDX_W-1:0] cidx [8];
  logic [3:0]  cnt, coff;
  logic [7:0]  xi, xj, z, step_op, ma, mb, prod, y_sel, yc;
  logic [ssr_pkg::IDX_W-1:0] yaddr, caddr;
  logic        seen;

  always_comb begin
    for (int n = 0; n < 8; n++) x[n] = coords_r[8*n +: 8];
  end

  always_comb begin
    cnt  = '0;
    coff = '0;
    for (int n = 0; n < 8; n++) begin
      bidx[n] = '0;
      cidx[n] = '0;
    end
    for (int n = 0; n < SHARE_SLOTS; n++) begin
      if (x[n] != 8'd0) begin
        coff = cnt - thr_r;
        if (cnt < thr_r) bidx[cnt[2:0]] = 3'(n);
        else if (cnt < integ_r) cidx[coff[2:0]] = 3'(n);
        cnt = cnt + 4'd1;
      end
    end
  end

  assign sts.bad = (thr_r == 4'd0) || (thr_r > 4'(SHARE_SLOTS)) || (integ_r < thr_r) ||
                   (integ_r > 4'(SHARE_SLOTS)) || (cnt < integ_r);
  assign sts.nb  = thr_r;
  assign sts.nc  = 3'(integ_r - thr_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign caddr = cidx[3'(cmd.tgt - 3'd1)];
  assign xi    = x[bidx[cmd.i]];
  assign xj    = x[bidx[cmd.j]];
  assign z     = (cmd.tgt == '0) ? 8'd0 : x[caddr];
  assign yaddr = (cmd.op == ssr_pkg::OP_TGT_END) ? caddr : bidx[cmd.i];
  assign y_sel = y_r[yaddr];
  assign yc    = y_sel;

  always_comb begin
    step_op = 8'd1;
    if (cmd.i != cmd.j) begin
      step_op = (cmd.op == ssr_pkg::OP_DEN_STEP) ? (xi ^ xj) : (z ^ xj);
    end
    ma = acc_r;
    mb = step_op;
    case (cmd.op)
      ssr_pkg::OP_INV_SQ: begin
        ma = sq_r;
        mb = sq_r;
      end
      ssr_pkg::OP_INV_MUL: mb = sq_r;
      ssr_pkg::OP_Y_ACC:   mb = y_sel;
      default: ;
    endcase
  end

  assign prod = ssr_pkg::gf_mul(ma, mb, poly_r[7:0]);
  assign seen = flag_r | (!sts.bad & mism_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coords_r <= '0;
      thr_r    <= 4'd1;
      integ_r  <= 4'd1;
      poly_r   <= ssr_pkg::POLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssr_pkg::CFG_COORDS: coords_r <= cfg_wdata;
        ssr_pkg::CFG_THR:    thr_r    <= cfg_wdata[3:0];
        ssr_pkg::CFG_INTEG:  integ_r  <= cfg_wdata[3:0];
        ssr_pkg::CFG_POLY:   poly_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ssr_pkg::OP_LOAD: begin
        for (int n = 0; n < SHARE_SLOTS; n++) y_r[n] <= in_data[8*n +: 8];
        final_r  <= in_last;
        secret_r <= 8'd0;
        mism_r   <= 1'b0;
      end
      ssr_pkg::OP_TGT_INIT: pred_r <= 8'd0;
      ssr_pkg::OP_DEN_INIT: acc_r  <= 8'd1;
      ssr_pkg::OP_DEN_STEP, ssr_pkg::OP_INV_MUL, ssr_pkg::OP_NUM_STEP: acc_r <= prod;
      ssr_pkg::OP_INV_INIT: begin
        sq_r  <= acc_r;
        acc_r <= 8'd1;
      end
      ssr_pkg::OP_INV_SQ: sq_r   <= prod;
      ssr_pkg::OP_Y_ACC:  pred_r <= pred_r ^ prod;
      ssr_pkg::OP_TGT_END: begin
        if (cmd.tgt == '0) secret_r <= pred_r;
        else if (pred_r != yc) mism_r <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
    end else if (cmd.op == ssr_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
      flag_r      <= final_r ? 1'b0 : seen;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ssr_pkg::OP_OUT) begin
      out_data_r <= {5'd0, seen,
                     sts.bad ? ssr_pkg::ST_BAD :
                     (mism_r ? ssr_pkg::ST_MISMATCH : ssr_pkg::ST_OK),
                     sts.bad ? 8'd0 : secret_r};
      out_last_r <= final_r;
    end
  end

  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

  `SSR_ASSERT_IMP(a_out_no_overwrite, cmd.op == ssr_pkg::OP_OUT, !out_valid_r || out_ready)
  `SSR_ASSERT_NXT(a_flag_clear, cmd.op == ssr_pkg::OP_OUT && final_r, !flag_r)

endmodule

// File: rtl/shamir_secret_recombine_gf256_unit.sv
`timescale 1ns / 1ps
// Shamir recombination over GF(2^8), one byte position per word. Each input word
// is worked on alone by one shared field multiplier. Per target point (the secret
// at zero, then each check share) one step clears the sum and one closes it. Per
// basis share the unit forms the denominator, its inverse by square-and-multiply,
// the numerator, and then accumulates. Bad settings go straight to the result.
// A finished result waits in the output state while the previous one still waits
// on out_tready. The result sits in an output register, so the next word is taken
// while it waits.
module shamir_secret_recombine_gf256_unit #(
  parameter int SHARE_SLOTS = ssr_pkg::SHARE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // share_byte_0 .. share_byte_7
  input  logic        in_tlast,   // final_position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // secret_byte, status, mismatch_seen, zero fill
  output logic        out_tlast   // final_result
);

  ssr_pkg::cmd_t cmd;
  ssr_pkg::sts_t sts;
  logic          in_fire;

  assign in_fire = in_tvalid && in_tready;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssr_dp #(.SHARE_SLOTS(SHARE_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: sim/shamir_secret_recombine_gf256_unit_tb.sv
`timescale 1ns / 1ps
module shamir_secret_recombine_gf256_unit_tb;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [7:0] secret;
    logic [1:0] status;
    logic       seen;
    logic       last;
  } recovery_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  logic [63:0] coords_q;
  logic [3:0]  thr_q;
  logic [3:0]  integ_q;
  logic [8:0]  poly_q;
  logic        sticky_q;

  recovery_t   pending_q[$];
  int          errors;
  int          cycles;
  bit          quiet_in;
  bit          quiet_out;
  int          out_hold;
  logic [7:0]  coef[8];

  shamir_secret_recombine_gf256_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = '0;
    sh  = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc ^= sh;
      sh = sh[7] ? ({sh[6:0], 1'b0} ^ poly_q[7:0]) : {sh[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [7:0] finv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'd1;
    p = a;
    for (int n = 0; n < 7; n++) begin
      p = fmul(p, p);
      r = fmul(r, p);
    end
    return r;
  endfunction

  function automatic recovery_t recover(input logic [63:0] shares, input logic last);
    recovery_t  res;
    logic [7:0] xs[8];
    logic [7:0] ys[8];
    logic [7:0] guess[8];
    int         basis[8];
    int         chk[8];
    int         nb;
    int         nc;
    bit         bad;
    logic [7:0] num;
    logic [7:0] den;
    logic [7:0] dinv;
    logic [7:0] t;
    nb = 0;
    nc = 0;
    res = '0;
    for (int n = 0; n < 8; n++) begin
      xs[n] = coords_q[8*n +: 8];
      ys[n] = shares[8*n +: 8];
      guess[n] = '0;
    end
    bad = (thr_q == 0) || (thr_q > 8) || (integ_q < thr_q) || (integ_q > 8);
    if (!bad) begin
      for (int n = 0; n < 8; n++) begin
        if (xs[n] != 0) begin
          if (nb < thr_q) begin
            basis[nb] = n;
            nb++;
          end else if (nb + nc < integ_q) begin
            chk[nc] = n;
            nc++;
          end
        end
      end
      if (nb < thr_q || nb + nc < integ_q) bad = 1;
    end
    if (bad) begin
      res.status = ssr_pkg::ST_BAD;
    end else begin
      res.status = ssr_pkg::ST_OK;
      for (int i = 0; i < nb; i++) begin
        num = 8'd1;
        den = 8'd1;
        for (int j = 0; j < nb; j++) begin
          if (j != i) begin
            num = fmul(num, xs[basis[j]]);
            den = fmul(den, xs[basis[i]] ^ xs[basis[j]]);
          end
        end
        dinv = finv(den);
        res.secret ^= fmul(fmul(num, dinv), ys[basis[i]]);
        for (int k = 0; k < nc; k++) begin
          t = dinv;
          for (int j = 0; j < nb; j++)
            if (j != i) t = fmul(t, xs[chk[k]] ^ xs[basis[j]]);
          guess[k] ^= fmul(t, ys[basis[i]]);
        end
      end
      for (int k = 0; k < nc; k++) begin
        if (guess[k] != ys[chk[k]]) begin
          res.status = ssr_pkg::ST_MISMATCH;
          sticky_q = 1'b1;
        end
      end
    end
    res.seen = sticky_q;
    res.last = last;
    if (last) sticky_q = 1'b0;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ssr_pkg::CFG_COORDS: coords_q = val;
      ssr_pkg::CFG_THR:    thr_q    = val[3:0];
      ssr_pkg::CFG_INTEG:  integ_q  = val[3:0];
      default:             poly_q   = val[8:0];
    endcase
  endtask

  // drop the input and hold off until the block has drained
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic setup(input logic [63:0] xs, input logic [3:0] thr,
                       input logic [3:0] integ, input logic [8:0] poly);
    drain();
    write_reg(ssr_pkg::CFG_COORDS, xs);
    write_reg(ssr_pkg::CFG_THR, {60'd0, thr});
    write_reg(ssr_pkg::CFG_INTEG, {60'd0, integ});
    write_reg(ssr_pkg::CFG_POLY, {55'd0, poly});
  endtask

  task automatic send_word(input logic [63:0] shares, input logic last);
    int gap;
    recovery_t exp_word;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= shares;
    in_tlast  <= last;
    exp_word = recover(shares, last);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(exp_word);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // evaluate the random sharing polynomial at each nonzero slot coordinate
  function automatic logic [63:0] make_shares(input int deg);
    logic [63:0] s;
    logic [7:0]  acc;
    logic [7:0]  xv;
    s = rand64();
    for (int n = 0; n < 8; n++) begin
      xv = coords_q[8*n +: 8];
      if (xv != 0) begin
        acc = '0;
        for (int k = deg; k >= 0; k--) acc = fmul(acc, xv) ^ coef[k];
        s[8*n +: 8] = acc;
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] distinct_coords(input int present);
    logic [63:0] xs;
    logic [7:0]  v;
    bit          dup;
    int          placed;
    xs = '0;
    placed = 0;
    while (placed < present) begin
      int slot;
      slot = $urandom_range(0, 7);
      if (xs[8*slot +: 8] == 0) begin
        do begin
          v = 8'($urandom_range(1, 255));
          dup = 0;
          for (int n = 0; n < 8; n++) if (xs[8*n +: 8] == v) dup = 1;
        end while (dup);
        xs[8*slot +: 8] = v;
        placed++;
      end
    end
    return xs;
  endfunction

  task automatic test_reset_state();
    send_word(64'h0, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 1'b1);
    idle_input();
  endtask

  task automatic test_directed();
    setup(64'h0807_0605_0403_0201, 4'd8, 4'd8, 9'h11d);
    send_word(64'h0, 1'b0);
    send_word(64'hffff_ffff_ffff_ffff, 1'b1);
    setup(64'h0807_0605_0403_0201, 4'd1, 4'd8, 9'h11d);
    send_word(64'h1111_1111_1111_1111, 1'b0);
    send_word(64'h1111_1111_1111_1112, 1'b0);
    send_word(64'h0, 1'b1);
    setup(64'hff00_fe00_0000_0001, 4'd2, 4'd3, 9'h11d);
    send_word(rand64(), 1'b0);
    send_word(rand64(), 1'b1);
    setup(64'h0807_0605_0403_0201, 4'd0, 4'd4, 9'h11d);
    send_word(rand64(), 1'b0);
    setup(64'h0807_0605_0403_0201, 4'd9, 4'd9, 9'h11d);
    send_word(rand64(), 1'b0);
    setup(64'h0807_0605_0403_0201, 4'd5, 4'd4, 9'h11d);
    send_word(rand64(), 1'b0);
    setup(64'h0807_0605_0403_0201, 4'd3, 4'd15, 9'h11d);
    send_word(rand64(), 1'b1);
    setup(64'h0000_0000_0003_0201, 4'd3, 4'd4, 9'h11d);
    send_word(rand64(), 1'b0);
    setup(64'h0000_0000_0003_0201, 4'd4, 4'd4, 9'h11d);
    send_word(rand64(), 1'b1);
    setup(64'h0000_0005_0003_0303, 4'd3, 4'd5, 9'h100);
    send_word(rand64(), 1'b0);
    send_word(rand64(), 1'b1);
    setup(64'h0102_0304_0506_0708, 4'd4, 4'd7, 9'h1ff);
    send_word(rand64(), 1'b0);
    setup(64'h0102_0304_0506_0708, 4'd4, 4'd8, 9'h0ff);
    send_word(rand64(), 1'b1);
    idle_input();
  endtask

  task automatic test_random_secrets();
    int          thr;
    int          integ;
    int          present;
    int          kind;
    int          words;
    int          slot;
    logic [8:0]  poly;
    logic [63:0] xs;
    logic [63:0] shares;
    for (int phase = 0; phase < 60; phase++) begin
      kind = $urandom_range(0, 99);
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      integ = thr + $urandom_range(0, 8 - thr);
      if (integ > 6 && thr < 4) integ = $urandom_range(thr, 6);
      present = $urandom_range(integ, 8);
      xs = distinct_coords(present);
      poly = ($urandom_range(0, 3) != 0) ? 9'h11d : 9'($urandom_range(0, 511));
      if (kind < 6) begin
        thr = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15);
      end else if (kind < 10) begin
        integ = $urandom_range(0, 1) ? $urandom_range(9, 15) : $urandom_range(0, thr - 1);
      end else if (kind < 14) begin
        xs = distinct_coords($urandom_range(0, integ - 1));
      end else if (kind < 20) begin
        slot = $urandom_range(1, 7);
        xs[8*slot +: 8] = xs[8*(slot-1) +: 8];
      end
      setup(xs, 4'(thr), 4'(integ), poly);
      quiet_in = ($urandom_range(0, 4) == 0);
      words = $urandom_range(15, 40);
      for (int w = 0; w < words; w++) begin
        for (int k = 0; k < 8; k++) coef[k] = 8'($urandom);
        if (thr >= 1 && thr <= 8) shares = make_shares(thr - 1);
        else shares = rand64();
        if ($urandom_range(0, 4) == 0) begin
          slot = $urandom_range(0, 7);
          shares[8*slot +: 8] ^= 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 19) == 0) shares = rand64();
        send_word(shares, ($urandom_range(0, 7) == 0) || (w == words - 1));
      end
      quiet_in = 0;
      idle_input();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold   <= 0;
    end else if (quiet_out) begin
      out_tready <= 1'b1;
    end else if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold   <= out_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) out_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && ($urandom_range(0, 299) == 0)) quiet_out <= ~quiet_out;
  end

  always @(posedge clk) begin
    recovery_t want;
    recovery_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[9:8], out_tdata[10], out_tlast};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %h last %b", out_tdata, out_tlast);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: secret %h/%h status %0d/%0d seen %b/%b last %b/%b",
                     want.secret, got.secret, want.status, got.status,
                     want.seen, got.seen, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("shamir_secret_recombine_gf256_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    errors    = 0;
    cycles    = 0;
    quiet_in  = 0;
    quiet_out = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    coords_q  = '0;
    thr_q     = 4'd1;
    integ_q   = 4'd1;
    poly_q    = ssr_pkg::POLY_RESET;
    sticky_q  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random_secrets();
    drain();
    repeat (600) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("shamir_secret_recombine_gf256_unit_tb OK");
    end else begin
      $display("shamir_secret_recombine_gf256_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
